// ===== rtl/pmtss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pmtss_pkg
// Shared types and constants for the PMT section stream selector.
// ----------------------------------------------------------------------------
package pmtss_pkg;

  localparam int PROGRAM_SLOTS_DEF = 8;
  localparam int SLOT_W            = 3;

  localparam logic ACT_SECTION = 1'b0;
  localparam logic ACT_TABLE   = 1'b1;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_LEN_ERR = 2'd1;
  localparam logic [1:0] STATUS_NO_PROG = 2'd2;

  localparam logic [7:0] ST_MPEG1_VIDEO = 8'h01;
  localparam logic [7:0] ST_MPEG2_VIDEO = 8'h02;
  localparam logic [7:0] ST_H264_VIDEO  = 8'h1b;
  localparam logic [7:0] ST_MPEG1_AUDIO = 8'h03;
  localparam logic [7:0] ST_MPEG2_AUDIO = 8'h04;
  localparam logic [7:0] ST_AAC_AUDIO   = 8'h11;

  typedef enum logic [2:0] {
    PH_HEADER    = 3'd0,
    PH_PROG_INFO = 3'd1,
    PH_TYPE      = 3'd2,
    PH_PID_HI    = 3'd3,
    PH_PID_LO    = 3'd4,
    PH_ES_LEN_HI = 3'd5,
    PH_ES_LEN_LO = 3'd6,
    PH_ES_INFO   = 3'd7
  } phase_t;

  typedef struct packed {
    logic              action;
    logic [7:0]        data_byte;
    logic              last_byte;
    logic [SLOT_W-1:0] entry_index;
    logic [15:0]       entry_program;
    logic              entry_valid;
  } in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [15:0]       program_number;
    logic [SLOT_W-1:0] program_slot;
    logic [12:0]       video_pid;
    logic [12:0]       audio_pid;
  } out_t;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } match_t;

endpackage
`default_nettype wire

// ===== rtl/pmt_section_stream_selector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pmt_section_stream_selector
// Parses a PMT section one byte per beat: checks section_length, looks the
// program up in the program table and keeps the last video and audio PIDs.
// ----------------------------------------------------------------------------
// Result path: a last section byte passes the input register, then its result is registered.
// Throughput: one beat per cycle, section bytes and table writes alike; only a
//   last byte waits in the input register while an earlier result is held.
// Reset: synchronous on rst_n; clears section state, both valid flags and all
//   program table valid bits.
module pmt_section_stream_selector
  import pmtss_pkg::*;
#(
  parameter int PROGRAM_SLOTS = PROGRAM_SLOTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  localparam logic [10:0] COUNT_LIMIT = 11'd1024;
  localparam logic [10:0] POS_LEN_HI  = 11'd1;
  localparam logic [10:0] POS_LEN_LO  = 11'd2;
  localparam logic [10:0] POS_PROG_HI = 11'd3;
  localparam logic [10:0] POS_PROG_LO = 11'd4;
  localparam logic [10:0] POS_INFO_HI = 11'd10;
  localparam logic [10:0] POS_INFO_LO = 11'd11;
  localparam logic [10:0] POS_LOOP    = 11'd12;
  localparam logic [10:0] MIN_COUNT   = 11'd5;

  // input register
  logic s1_valid_r;
  in_t  s1_data_r;
  logic s1_go;
  logic produce;

  // section state
  logic [10:0] pos_r,    pos_upd,    pos_nxt;
  logic [11:0] dlen_r,   dlen_upd,   dlen_nxt;
  logic [15:0] prog_r,   prog_upd,   prog_nxt;
  logic [11:0] info_r,   info_upd,   info_nxt;
  phase_t      phase_r,  phase_upd,  phase_nxt;
  logic [7:0]  etype_r,  etype_upd,  etype_nxt;
  logic [4:0]  pidhi_r,  pidhi_upd,  pidhi_nxt;
  logic [12:0] video_r,  video_upd,  video_nxt;
  logic [12:0] audio_r,  audio_upd,  audio_nxt;

  // result register
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r,  out_data_nxt;

  logic   section_beat;
  logic   len_err;
  match_t match;
  out_t   result;

  assign section_beat = s1_valid_r && (s1_data_r.action == ACT_SECTION);
  assign produce      = section_beat && s1_data_r.last_byte;
  assign s1_go        = s1_valid_r && (!produce || !out_valid_r || out_ready);
  assign in_ready     = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
  end

  pmtss_table #(
    .PROGRAM_SLOTS (PROGRAM_SLOTS)
  ) u_table (
    .clk            (clk),
    .rst_n          (rst_n),
    .wr_en          (s1_go && (s1_data_r.action == ACT_TABLE)),
    .wr_index       (s1_data_r.entry_index),
    .wr_valid       (s1_data_r.entry_valid),
    .wr_program     (s1_data_r.entry_program),
    .lookup_program (prog_upd),
    .match          (match)
  );

  // Section update for one byte.
  always_comb begin
    logic [7:0]  b;
    logic [11:0] info_tmp;
    b         = s1_data_r.data_byte;
    info_tmp  = '0;
    pos_upd   = pos_r;
    dlen_upd  = dlen_r;
    prog_upd  = prog_r;
    info_upd  = info_r;
    phase_upd = phase_r;
    etype_upd = etype_r;
    pidhi_upd = pidhi_r;
    video_upd = video_r;
    audio_upd = audio_r;

    if (section_beat) begin
      if (pos_r < COUNT_LIMIT) begin
        case (pos_r)
          POS_LEN_HI:  dlen_upd = {b[3:0], 8'h00};
          POS_LEN_LO:  dlen_upd = dlen_r | {4'h0, b};
          POS_PROG_HI: prog_upd = {b, 8'h00};
          POS_PROG_LO: prog_upd = prog_r | {8'h00, b};
          POS_INFO_HI: info_upd = {b[3:0], 8'h00};
          POS_INFO_LO: begin
            info_tmp  = info_r | {4'h0, b};
            info_upd  = info_tmp;
            phase_upd = (info_tmp == '0) ? PH_TYPE : PH_PROG_INFO;
          end
          default: begin
            // walk the ES loop only ahead of the CRC
            if ((pos_r >= POS_LOOP) && ((13'(pos_r) + 13'd1) < 13'(dlen_r))) begin
              case (phase_r)
                PH_PROG_INFO, PH_ES_INFO: begin
                  info_tmp = info_r - 12'd1;
                  info_upd = info_tmp;
                  if (info_tmp == '0) begin
                    phase_upd = PH_TYPE;
                  end
                end
                PH_TYPE: begin
                  etype_upd = b;
                  phase_upd = PH_PID_HI;
                end
                PH_PID_HI: begin
                  pidhi_upd = b[4:0];
                  phase_upd = PH_PID_LO;
                end
                PH_PID_LO: begin
                  if (etype_r inside {ST_MPEG1_VIDEO, ST_MPEG2_VIDEO, ST_H264_VIDEO}) begin
                    video_upd = {pidhi_r, b};
                  end else if (etype_r inside {ST_MPEG1_AUDIO, ST_MPEG2_AUDIO,
                                               ST_AAC_AUDIO}) begin
                    audio_upd = {pidhi_r, b};
                  end
                  phase_upd = PH_ES_LEN_HI;
                end
                PH_ES_LEN_HI: begin
                  info_upd  = {b[3:0], 8'h00};
                  phase_upd = PH_ES_LEN_LO;
                end
                PH_ES_LEN_LO: begin
                  info_tmp  = info_r | {4'h0, b};
                  info_upd  = info_tmp;
                  phase_upd = (info_tmp == '0) ? PH_TYPE : PH_ES_INFO;
                end
                default: ;
              endcase
            end
          end
        endcase
      end
      // saturate one past the limit to mark an overlong section
      if (pos_r <= COUNT_LIMIT) begin
        pos_upd = pos_r + 11'd1;
      end
    end
  end

  // Result on the last byte.
  assign len_err = (pos_upd > COUNT_LIMIT) || (pos_upd < MIN_COUNT) ||
                   (13'(pos_upd) != (13'(dlen_upd) + 13'd3));

  always_comb begin
    result                = '0;
    result.program_number = prog_upd;
    if (len_err) begin
      result.status = STATUS_LEN_ERR;
    end else if (match.hit) begin
      result.status       = STATUS_OK;
      result.program_slot = match.slot;
      result.video_pid    = video_upd;
      result.audio_pid    = audio_upd;
    end else begin
      result.status = STATUS_NO_PROG;
    end
  end

  always_comb begin
    pos_nxt   = pos_r;
    dlen_nxt  = dlen_r;
    prog_nxt  = prog_r;
    info_nxt  = info_r;
    phase_nxt = phase_r;
    etype_nxt = etype_r;
    pidhi_nxt = pidhi_r;
    video_nxt = video_r;
    audio_nxt = audio_r;
    if (s1_go) begin
      if (produce) begin
        // drop all section state once the result is out
        pos_nxt   = '0;
        dlen_nxt  = '0;
        prog_nxt  = '0;
        info_nxt  = '0;
        phase_nxt = PH_HEADER;
        etype_nxt = '0;
        pidhi_nxt = '0;
        video_nxt = '0;
        audio_nxt = '0;
      end else begin
        pos_nxt   = pos_upd;
        dlen_nxt  = dlen_upd;
        prog_nxt  = prog_upd;
        info_nxt  = info_upd;
        phase_nxt = phase_upd;
        etype_nxt = etype_upd;
        pidhi_nxt = pidhi_upd;
        video_nxt = video_upd;
        audio_nxt = audio_upd;
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    if (s1_go && produce) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = result;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      dlen_r      <= '0;
      prog_r      <= '0;
      info_r      <= '0;
      phase_r     <= PH_HEADER;
      etype_r     <= '0;
      pidhi_r     <= '0;
      video_r     <= '0;
      audio_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      dlen_r      <= dlen_nxt;
      prog_r      <= prog_nxt;
      info_r      <= info_nxt;
      phase_r     <= phase_nxt;
      etype_r     <= etype_nxt;
      pidhi_r     <= pidhi_nxt;
      video_r     <= video_nxt;
      audio_r     <= audio_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== rtl/pmtss_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pmtss_table
// Program table: per-slot valid bit and program number, written one slot
// per beat, with a lowest-slot-first match on a program number.
// ----------------------------------------------------------------------------
module pmtss_table
  import pmtss_pkg::*;
#(
  parameter int PROGRAM_SLOTS = PROGRAM_SLOTS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [SLOT_W-1:0] wr_index,
  input  wire logic              wr_valid,
  input  wire logic [15:0]       wr_program,
  input  wire logic [15:0]       lookup_program,
  output match_t                 match
);

  // Only slots reachable by the index field are stored.
  localparam int NUM_SLOTS = (PROGRAM_SLOTS < (1 << SLOT_W)) ? PROGRAM_SLOTS : (1 << SLOT_W);

  logic [NUM_SLOTS-1:0] valid_r;
  logic [15:0]          program_r [NUM_SLOTS];

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_slot
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[g] <= 1'b0;
      end else if (wr_en && (wr_index == SLOT_W'(g))) begin
        valid_r[g] <= wr_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (wr_en && (wr_index == SLOT_W'(g))) begin
        program_r[g] <= wr_program;
      end
    end
  end

  // Scan from the top so the lowest matching slot wins.
  always_comb begin
    match = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (valid_r[i] && (program_r[i] == lookup_program)) begin
        match.hit  = 1'b1;
        match.slot = SLOT_W'(i);
      end
    end
  end

endmodule
`default_nettype wire
